// File: src/okvt_pkg.sv
// shared types and constants of the ordered key/value table
package okvt_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ENTRY_W    = KEY_BITS + VALUE_BITS;

    // command codes
    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_LIST   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EXISTS    = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [KEY_BITS-1:0]   out_key;
        logic [VALUE_BITS-1:0] out_value;
        logic [IDX_W-1:0]      out_index;
        logic [CNT_W-1:0]      entry_count;
        logic                  last;
    } rsp_t;

    // pair memory access from the sequencer, entry is {key, value}
    typedef struct packed {
        logic               re;
        logic [IDX_W-1:0]   raddr;
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
    } ram_req_t;

endpackage

// File: src/okvt_ram.sv
// generic single-write single-read synchronous ram, registered read data
module okvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/okvt_ctrl.sv
// sequencer of the ordered key/value table: scan, append, shift-down and list
module okvt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  okvt_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output okvt_pkg::rsp_t    rsp,
    output okvt_pkg::ram_req_t ram_req,
    input  logic [okvt_pkg::ENTRY_W-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP,
        ST_SHIFT,
        ST_LIST
    } state_t;

    state_t                          state_reg, state_next;
    logic [okvt_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                            pend_reg, pend_next;
    logic                            shift_reg, shift_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [1:0]                      cmd_reg, cmd_next;
    logic [okvt_pkg::KEY_BITS-1:0]   key_reg, key_next;
    logic [okvt_pkg::VALUE_BITS-1:0] value_reg, value_next;
    logic [okvt_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic [okvt_pkg::CNT_W-1:0]      pos_reg, pos_next;
    okvt_pkg::rsp_t                  res_reg, res_next;
    okvt_pkg::rsp_t                  rsp_reg, rsp_next;

    logic                            slot_free;
    logic                            hit;
    logic [okvt_pkg::KEY_BITS-1:0]   rd_key;
    logic [okvt_pkg::VALUE_BITS-1:0] rd_value;
    logic [okvt_pkg::CNT_W-1:0]      pos_inc;
    logic [okvt_pkg::CNT_W-1:0]      idx_inc;
    logic [okvt_pkg::CNT_W-1:0]      cnt_inc;
    logic [okvt_pkg::CNT_W-1:0]      cnt_dec;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign rd_key    = ram_rdata[okvt_pkg::ENTRY_W-1 -: okvt_pkg::KEY_BITS];
    assign rd_value  = ram_rdata[okvt_pkg::VALUE_BITS-1:0];
    assign hit       = pend_reg && (rd_key == key_reg);
    assign pos_inc   = pos_reg + okvt_pkg::CNT_W'(1);
    assign idx_inc   = idx_reg + okvt_pkg::CNT_W'(1);
    assign cnt_inc   = cnt_reg + okvt_pkg::CNT_W'(1);
    assign cnt_dec   = cnt_reg - okvt_pkg::CNT_W'(1);

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        shift_next     = shift_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        ram_req        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next   = req.cmd;
                    key_next   = req.key;
                    value_next = req.value;
                    idx_next   = '0;
                    pos_next   = '0;
                    pend_next  = 1'b0;
                    shift_next = 1'b0;
                    if (req.cmd == okvt_pkg::CMD_LIST)
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_next             = '0;
                            res_next.status      = okvt_pkg::ST_NOT_FOUND;
                            res_next.entry_count = cnt_reg;
                            res_next.last        = 1'b1;
                            state_next           = ST_RESP;
                        end
                        else
                        begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = '0;
                            state_next    = ST_LIST;
                        end
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    res_next.status      = (cmd_reg == okvt_pkg::CMD_PUT) ?
                                           okvt_pkg::ST_EXISTS : okvt_pkg::ST_OK;
                    res_next.out_key     = rd_key;
                    res_next.out_value   = rd_value;
                    res_next.out_index   = pos_reg[okvt_pkg::IDX_W-1:0];
                    res_next.entry_count = cnt_reg;
                    res_next.last        = 1'b1;
                    if (cmd_reg == okvt_pkg::CMD_REMOVE)
                    begin
                        // later entries move down one place after the response
                        cnt_next             = cnt_dec;
                        res_next.entry_count = cnt_dec;
                        shift_next           = 1'b1;
                        idx_next             = pos_inc;
                        pend_next            = 1'b0;
                    end
                    state_next = ST_RESP;
                end
                else if (idx_reg < cnt_reg)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_reg[okvt_pkg::IDX_W-1:0];
                    pos_next      = idx_reg;
                    idx_next      = idx_inc;
                    pend_next     = 1'b1;
                end
                else
                begin
                    res_next             = '0;
                    res_next.last        = 1'b1;
                    res_next.entry_count = cnt_reg;
                    res_next.status      = okvt_pkg::ST_NOT_FOUND;
                    if (cmd_reg == okvt_pkg::CMD_PUT)
                    begin
                        if (cnt_reg == okvt_pkg::CNT_W'(okvt_pkg::DEPTH))
                        begin
                            res_next.status = okvt_pkg::ST_FULL;
                        end
                        else
                        begin
                            // append at the tail
                            ram_req.we           = 1'b1;
                            ram_req.waddr        = cnt_reg[okvt_pkg::IDX_W-1:0];
                            ram_req.wdata        = {key_reg, value_reg};
                            cnt_next             = cnt_inc;
                            res_next.status      = okvt_pkg::ST_OK;
                            res_next.out_key     = key_reg;
                            res_next.out_value   = value_reg;
                            res_next.out_index   = cnt_reg[okvt_pkg::IDX_W-1:0];
                            res_next.entry_count = cnt_inc;
                        end
                    end
                    pend_next  = 1'b0;
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = shift_reg ? ST_SHIFT : ST_IDLE;
                end
            end

            ST_SHIFT:
            begin
                // pos is the destination, idx the next source
                if (pend_reg)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg[okvt_pkg::IDX_W-1:0];
                    ram_req.wdata = ram_rdata;
                    pos_next      = pos_inc;
                end
                if (idx_reg <= cnt_reg)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_reg[okvt_pkg::IDX_W-1:0];
                    idx_next      = idx_inc;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        shift_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_LIST:
            begin
                if (slot_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = okvt_pkg::ST_OK;
                    rsp_next.out_key     = rd_key;
                    rsp_next.out_value   = rd_value;
                    rsp_next.out_index   = pos_reg[okvt_pkg::IDX_W-1:0];
                    rsp_next.entry_count = cnt_reg;
                    rsp_next.last        = (pos_inc == cnt_reg);
                    if (pos_inc == cnt_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = pos_inc[okvt_pkg::IDX_W-1:0];
                        pos_next      = pos_inc;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            shift_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            shift_reg     <= shift_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        value_reg <= value_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

endmodule

// File: src/ordered_key_value_table.sv
// top level of the ordered key/value table
//
// a table of up to 16 key/value pairs kept in insertion order in one
// synchronous pair memory with a single read and a single write port. each
// request transaction carries cmd (put, get, remove, list), key and value; a
// request is taken only while the sequencer is idle, and every response
// transaction carries status, the pair concerned, its position, the entry
// count after the operation and a last flag. put, get and remove scan the
// stored pairs one memory read per cycle; remove then moves the later pairs
// down one place. list gives one response per stored pair, one per cycle
// while the consumer keeps up, or a single not_found response on an empty
// table. the single read port of the pair memory sets this pace. the
// response sits in an output register, so a new request can be taken while
// the last response of the previous one still waits
module ordered_key_value_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  okvt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output okvt_pkg::rsp_t rsp
);

    // memory access from the sequencer and the read data back
    okvt_pkg::ram_req_t               ram_req;
    logic [okvt_pkg::ENTRY_W-1:0]     ram_rdata;

    // pair memory, never cleared: only entries that hold stored pairs are read
    okvt_ram #(
        .WIDTH (okvt_pkg::ENTRY_W),
        .DEPTH (okvt_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // scan, append, shift-down and list sequencer with the output register
    okvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

endmodule

// File: src/okvt_checker.sv
// port-level assertions of the ordered key/value table and their binding
module okvt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input okvt_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input okvt_pkg::rsp_t rsp
);

    // a waiting request holds
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while waiting");

    // a stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

    // count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.entry_count <= okvt_pkg::CNT_W'(okvt_pkg::DEPTH))
    else $error("entry count beyond table size");

    // a miss carries a zero pair and ends its transaction group
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == okvt_pkg::ST_NOT_FOUND |->
        rsp.out_key == '0 && rsp.out_value == '0 && rsp.out_index == '0 && rsp.last)
    else $error("not_found response with data");

    // full only when every entry is in use
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == okvt_pkg::ST_FULL |->
        rsp.entry_count == okvt_pkg::CNT_W'(okvt_pkg::DEPTH) && rsp.last)
    else $error("full response with room left");

endmodule

bind ordered_key_value_table okvt_checker u_okvt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// File: tb/tb_ordered_key_value_table.sv
// self-checking testbench for the ordered key/value table
`timescale 1ns / 1ps

module tb_ordered_key_value_table;

    // cycles with no transaction on either channel before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // quiet cycles after the last response, well past one full scan and shift
    localparam int TAIL_CYCLES = 60;
    localparam int MIX_ITEMS   = 35;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic           req_valid = 1'b0;
    logic           req_ready;
    okvt_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    okvt_pkg::rsp_t rsp;

    // request transactions waiting for the driver
    okvt_pkg::req_t queued_cmds[$];
    // responses the table must still produce, oldest first
    okvt_pkg::rsp_t awaited_rsp[$];

    // shadow copy of the table contents
    logic [okvt_pkg::KEY_BITS-1:0]   shadow_key[okvt_pkg::DEPTH];
    logic [okvt_pkg::VALUE_BITS-1:0] shadow_val[okvt_pkg::DEPTH];
    int                              shadow_count = 0;

    // idling knobs, in percent per cycle
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int error_count = 0;
    int quiet_cycles = 0;

    ordered_key_value_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
        error_count++;
    endtask

    // queue one expected response, entry count taken after the operation
    function automatic void await_result(input logic [1:0] status,
                                         input logic [okvt_pkg::KEY_BITS-1:0] k,
                                         input logic [okvt_pkg::VALUE_BITS-1:0] v,
                                         input int idx, input logic fin);
        okvt_pkg::rsp_t r;
        r.status      = status;
        r.out_key     = k;
        r.out_value   = v;
        r.out_index   = okvt_pkg::IDX_W'(idx);
        r.entry_count = okvt_pkg::CNT_W'(shadow_count);
        r.last        = fin;
        awaited_rsp.push_back(r);
    endfunction

    // apply one accepted command to the shadow table and queue its responses
    function automatic void model_table_op(input okvt_pkg::req_t r);
        int pos;
        logic [okvt_pkg::KEY_BITS-1:0]   gone_key;
        logic [okvt_pkg::VALUE_BITS-1:0] gone_val;
        pos = -1;
        for (int i = 0; i < shadow_count; i++)
            if (pos < 0 && shadow_key[i] == r.key)
                pos = i;
        case (r.cmd)
            okvt_pkg::CMD_PUT:
            begin
                // a present key wins over a full table
                if (pos >= 0)
                    await_result(okvt_pkg::ST_EXISTS, shadow_key[pos], shadow_val[pos],
                                 pos, 1'b1);
                else if (shadow_count >= okvt_pkg::DEPTH)
                    await_result(okvt_pkg::ST_FULL, '0, '0, 0, 1'b1);
                else
                begin
                    shadow_key[shadow_count] = r.key;
                    shadow_val[shadow_count] = r.value;
                    shadow_count++;
                    await_result(okvt_pkg::ST_OK, r.key, r.value, shadow_count - 1, 1'b1);
                end
            end
            okvt_pkg::CMD_GET:
            begin
                if (pos >= 0)
                    await_result(okvt_pkg::ST_OK, shadow_key[pos], shadow_val[pos],
                                 pos, 1'b1);
                else
                    await_result(okvt_pkg::ST_NOT_FOUND, '0, '0, 0, 1'b1);
            end
            okvt_pkg::CMD_REMOVE:
            begin
                if (pos >= 0)
                begin
                    gone_key = shadow_key[pos];
                    gone_val = shadow_val[pos];
                    // close the gap, index reported is the one before removal
                    for (int i = pos; i + 1 < shadow_count; i++)
                    begin
                        shadow_key[i] = shadow_key[i + 1];
                        shadow_val[i] = shadow_val[i + 1];
                    end
                    shadow_count--;
                    await_result(okvt_pkg::ST_OK, gone_key, gone_val, pos, 1'b1);
                end
                else
                    await_result(okvt_pkg::ST_NOT_FOUND, '0, '0, 0, 1'b1);
            end
            default:
            begin
                // list: one response per pair, or a lone not_found when empty
                if (shadow_count == 0)
                    await_result(okvt_pkg::ST_NOT_FOUND, '0, '0, 0, 1'b1);
                else
                    for (int i = 0; i < shadow_count; i++)
                        await_result(okvt_pkg::ST_OK, shadow_key[i], shadow_val[i], i,
                                     i + 1 == shadow_count);
            end
        endcase
    endfunction

    task automatic check_response(input okvt_pkg::rsp_t got);
        okvt_pkg::rsp_t want;
        if (awaited_rsp.size() == 0)
            report_mismatch("response with nothing awaited, key", got.out_key, '0);
        else
        begin
            want = awaited_rsp.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.out_key !== want.out_key)
                report_mismatch("out_key", got.out_key, want.out_key);
            if (got.out_value !== want.out_value)
                report_mismatch("out_value", got.out_value, want.out_value);
            if (got.out_index !== want.out_index)
                report_mismatch("out_index", 32'(got.out_index), 32'(want.out_index));
            if (got.entry_count !== want.entry_count)
                report_mismatch("entry_count", 32'(got.entry_count),
                                32'(want.entry_count));
            if (got.last !== want.last)
                report_mismatch("last", 32'(got.last), 32'(want.last));
        end
    endtask

    // driver: predicts on acceptance, then offers the next queued command
    // valid is only dropped right after a transaction, never while waiting
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                model_table_op(req);
            if (!req_valid || req_ready)
            begin
                if (queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req       <= queued_cmds.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor: checks every response transaction and throttles ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
                check_response(rsp);
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: a hung handshake ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_ordered_key_value_table: done, errors");
                $finish;
            end
        end
    end

    task automatic queue_req(input logic [1:0] cmd,
                             input logic [okvt_pkg::KEY_BITS-1:0] k,
                             input logic [okvt_pkg::VALUE_BITS-1:0] v);
        okvt_pkg::req_t r;
        r.cmd   = cmd;
        r.key   = k;
        r.value = v;
        queued_cmds.push_back(r);
    endtask

    // hold the sender until every command went out and every response came back
    task automatic wait_until_drained();
        while (queued_cmds.size() != 0 || req_valid || awaited_rsp.size() != 0)
            @(negedge clk);
    endtask

    // one random phase: fill past capacity, random mix on a small key pool,
    // then remove every pool key in random order so the table ends empty
    task automatic run_phase(input int send_pct, input int recv_pct);
        logic [okvt_pkg::KEY_BITS-1:0] key_pool[$];
        logic [okvt_pkg::KEY_BITS-1:0] k;
        logic [okvt_pkg::KEY_BITS-1:0] tmp;
        int sel;
        int j;
        logic fresh;
        wait_until_drained();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < okvt_pkg::DEPTH + 4; i++)
            key_pool.push_back($urandom);
        for (int i = 0; i < okvt_pkg::DEPTH + 2; i++)
            queue_req(okvt_pkg::CMD_PUT, key_pool[i], $urandom);
        // present key while full: exists must win over full
        queue_req(okvt_pkg::CMD_PUT, key_pool[$urandom_range(okvt_pkg::DEPTH - 1)],
                  $urandom);
        queue_req(okvt_pkg::CMD_LIST, $urandom, $urandom);
        for (int i = 0; i < MIX_ITEMS; i++)
        begin
            sel   = $urandom_range(99);
            fresh = ($urandom_range(99) >= 85);
            k     = fresh ? okvt_pkg::KEY_BITS'($urandom)
                          : key_pool[$urandom_range(key_pool.size() - 1)];
            if (sel < 40)
            begin
                queue_req(okvt_pkg::CMD_PUT, k, $urandom);
                if (fresh)
                    key_pool.push_back(k);
            end
            else if (sel < 65)
                queue_req(okvt_pkg::CMD_GET, k, $urandom);
            else if (sel < 85)
                queue_req(okvt_pkg::CMD_REMOVE, k, $urandom);
            else
                queue_req(okvt_pkg::CMD_LIST, $urandom, $urandom);
        end
        // shuffle so removals hit the head, the middle and the tail
        for (int i = key_pool.size() - 1; i > 0; i--)
        begin
            j           = $urandom_range(i);
            tmp         = key_pool[i];
            key_pool[i] = key_pool[j];
            key_pool[j] = tmp;
        end
        foreach (key_pool[i])
            queue_req(okvt_pkg::CMD_REMOVE, key_pool[i], $urandom);
        queue_req(okvt_pkg::CMD_LIST, $urandom, $urandom);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, field extremes, duplicate put, removal
        // from the head and the tail, list on empty and populated table
        queue_req(okvt_pkg::CMD_LIST,   32'h0000_0000, 32'h0000_0000);
        queue_req(okvt_pkg::CMD_GET,    32'h0000_0000, 32'hFFFF_FFFF);
        queue_req(okvt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(okvt_pkg::CMD_PUT,    32'h0000_0000, 32'hFFFF_FFFF);
        queue_req(okvt_pkg::CMD_PUT,    32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(okvt_pkg::CMD_PUT,    32'hA5A5_A5A5, 32'h5A5A_5A5A);
        queue_req(okvt_pkg::CMD_PUT,    32'h0000_0000, 32'h1234_5678);
        queue_req(okvt_pkg::CMD_GET,    32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(okvt_pkg::CMD_GET,    32'h5A5A_5A5A, 32'h0000_0000);
        queue_req(okvt_pkg::CMD_LIST,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(okvt_pkg::CMD_REMOVE, 32'h0000_0000, 32'h0000_0000);
        queue_req(okvt_pkg::CMD_LIST,   32'h0000_0000, 32'h0000_0000);
        queue_req(okvt_pkg::CMD_REMOVE, 32'hA5A5_A5A5, 32'h0000_0000);
        queue_req(okvt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(okvt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(okvt_pkg::CMD_LIST,   32'h0000_0000, 32'h0000_0000);

        // idling phases: none, sender gaps, receiver stalls, both
        run_phase(0, 0);
        run_phase(50, 0);
        run_phase(0, 50);
        run_phase(14, 14);

        wait_until_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (awaited_rsp.size() != 0)
            report_mismatch("responses never seen, count", 32'(awaited_rsp.size()), '0);
        if (error_count == 0)
            $display("tb_ordered_key_value_table: done, clean");
        else
            $display("tb_ordered_key_value_table: done, errors");
        $finish;
    end

endmodule

// File: files.f
src/okvt_pkg.sv
src/okvt_ram.sv
src/okvt_ctrl.sv
src/ordered_key_value_table.sv
src/okvt_checker.sv
tb/tb_ordered_key_value_table.sv
